>>> design/vag_adpcm_decoder_defines.svh
// Assertion macros for the VAG ADPCM decoder.
`ifndef VAG_ADPCM_DECODER_DEFINES_SVH
`define VAG_ADPCM_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VAGDEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define VAGDEC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define VAGDEC_ASSERT_IMP(label, ante, cons, msg)
`define VAGDEC_ASSERT_NEVER(label, cond, msg)
`endif
`endif

>>> design/vagdec_pkg.sv
// Shared types, constants and coefficient tables of the VAG ADPCM decoder.
package vagdec_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;
  localparam int unsigned FRAME_BYTES      = 16;
  localparam int unsigned SAMPLES_PER_FRAME = (FRAME_BYTES - 2) * 2;
  // channel field in a queued operation covers the largest channel count
  localparam int unsigned CH_W = 4;

  localparam logic [1:0] REG_CHANNELS     = 2'd0;
  localparam logic [1:0] REG_REPORT_START = 2'd1;
  localparam logic [1:0] REG_REPORT_END   = 2'd2;

  localparam logic [7:0] FLAG_STOP       = 8'h07;
  localparam int unsigned FLAG_LOOP_END   = 0;
  localparam int unsigned FLAG_LOOP_START = 2;

  // marker bits of a flag operation, in emission order
  localparam int unsigned MARK_LOOP_END   = 0;
  localparam int unsigned MARK_LOOP_START = 1;
  localparam int unsigned MARK_STOP       = 2;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_LOOP_END   = 2'd1,
    KIND_LOOP_START = 2'd2,
    KIND_END        = 2'd3
  } kind_e;

  typedef struct packed {
    logic            is_data;
    logic [7:0]      data;
    logic [3:0]      shift;
    logic [3:0]      filter;
    logic [CH_W-1:0] chan;
    logic [7:0]      slot0;
    logic [7:0]      slot1;
    logic [25:0]     block;
    logic [30:0]     base;
    logic [2:0]      marks;
  } op_t;

  function automatic logic signed [7:0] coef_recent(input logic [3:0] filter);
    logic signed [7:0] c;
    case (filter)
      4'd1:    c = 8'sd60;
      4'd2:    c = 8'sd115;
      4'd3:    c = 8'sd98;
      4'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_older(input logic [3:0] filter);
    logic signed [7:0] c;
    case (filter)
      4'd2:    c = -8'sd52;
      4'd3:    c = -8'sd55;
      4'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

>>> design/vag_adpcm_decoder.sv
// Channel     Dir  Payload
// s_axis      in   tdata[7:0] frame stream byte
// m_axis      out  tdata sample/slot/block/loop position, tuser result kind, tlast
// cfg         in   channel count, loop-start and loop-end report enables
//
// One byte is taken per cycle while the operation queue has room; the shift/filter
// header byte and a flag byte with no marks finish in the parser. A data byte
// gives two samples through the history multiply-add, one per cycle while the
// output is ready. Flag bytes give up to three results in the same way.
// Reset clears history, position, block count and loop flags at once.
// A stalled output fills the queue, after which s_axis_tready drops.
`include "vag_adpcm_decoder_defines.svh"
module vag_adpcm_decoder #(
  parameter int unsigned MAX_CHANNELS = vagdec_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned QUEUE_DEPTH  = vagdec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [15:0] sample_value, [23:16] slot,
                                      // [49:24] block_number, [80:50] loop_position
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast
);
  import vagdec_pkg::*;

  logic        push, full, pop, empty;
  op_t         op_in, op_head;
  logic [15:0] sample;
  logic [7:0]  slot;
  logic [25:0] block;
  logic [30:0] loop_pos;

  vagdec_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .q_full_i   (full),
    .push_o     (push),
    .op_o       (op_in)
  );

  vagdec_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (op_head)
  );

  vagdec_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (op_head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_sample_o (sample),
    .out_slot_o   (slot),
    .out_block_o  (block),
    .out_loop_o   (loop_pos),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, loop_pos, block, slot, sample};

  `VAGDEC_ASSERT_NEVER(a_push_full, push && full, "operation pushed into a full queue")
  `VAGDEC_ASSERT_IMP(a_end_last, m_axis_tvalid && m_axis_tuser == KIND_END, m_axis_tlast, "end of stream not last of its byte")
  `VAGDEC_ASSERT_IMP(a_sample_loop, m_axis_tvalid && m_axis_tuser == KIND_SAMPLE, loop_pos == 31'd0, "sample result carries a loop position")

endmodule

>>> design/vagdec_fifo.sv
// Short operation queue between the frame parser and the sample decoder.
module vagdec_fifo #(
  parameter int unsigned DEPTH = vagdec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vagdec_pkg::op_t  op_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output vagdec_pkg::op_t  head_o
);
  import vagdec_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  op_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

>>> design/vagdec_front.sv
// Frame parser: tracks frame position, channel and block, classifies bytes into operations.
module vagdec_front #(
  parameter int unsigned MAX_CHANNELS = vagdec_pkg::MAX_CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_addr_i,
  input  logic [3:0]       cfg_data_i,
  input  logic             in_valid_i,
  input  logic [7:0]       in_data_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output vagdec_pkg::op_t  op_o
);
  import vagdec_pkg::*;

  localparam int unsigned CurW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NchW = $clog2(MAX_CHANNELS + 1);

  logic [3:0]      channels_q;
  logic            rep_start_q, rep_end_q;
  logic [3:0]      pos_q, pos_d;
  logic [CurW-1:0] cur_q, cur_d;
  logic [3:0]      shift_q, shift_d, filter_q, filter_d;
  logic [25:0]     block_q, block_d;
  logic            start_seen_q, start_seen_d, end_seen_q, end_seen_d;
  logic            stopped_q, stopped_d;

  logic [NchW-1:0] nch;
  logic            accept;
  logic [4:0]      idx;
  logic [9:0]      prod;
  logic [CurW:0]   cur_inc;
  logic [2:0]      marks;

  always_comb begin
    if (channels_q == 4'd0) begin
      nch = NchW'(1);
    end else if (32'(channels_q) > MAX_CHANNELS) begin
      nch = NchW'(MAX_CHANNELS);
    end else begin
      nch = NchW'(channels_q);
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign idx  = {pos_q - 4'd2, 1'b0};
  assign prod = 10'(nch) * 10'(idx);

  always_comb begin
    marks = '0;
    marks[MARK_LOOP_END]   = in_data_i[FLAG_LOOP_END] && rep_end_q && !end_seen_q;
    marks[MARK_LOOP_START] = in_data_i[FLAG_LOOP_START] && rep_start_q && !start_seen_q;
    marks[MARK_STOP]       = (in_data_i == FLAG_STOP);
  end

  always_comb begin
    op_o.is_data = (pos_q >= 4'd2);
    op_o.data    = in_data_i;
    op_o.shift   = shift_q;
    op_o.filter  = filter_q;
    op_o.chan    = CH_W'(cur_q);
    op_o.slot0   = 8'(prod + 10'(cur_q));
    op_o.slot1   = 8'(prod + 10'(nch) + 10'(cur_q));
    op_o.block   = block_q;
    op_o.base    = 31'({block_q, 5'b0}) - 31'({block_q, 2'b0});
    op_o.marks   = marks;
  end

  assign push_o = accept && !stopped_q && ((pos_q >= 4'd2) || ((pos_q == 4'd1) && (|marks)));

  assign cur_inc = (CurW + 1)'(cur_q) + 1'b1;

  always_comb begin
    pos_d        = pos_q;
    cur_d        = cur_q;
    shift_d      = shift_q;
    filter_d     = filter_q;
    block_d      = block_q;
    start_seen_d = start_seen_q;
    end_seen_d   = end_seen_q;
    stopped_d    = stopped_q;
    if (accept && !stopped_q) begin
      if (pos_q == 4'd0) begin
        shift_d  = in_data_i[3:0];
        filter_d = in_data_i[7:4];
      end else if (pos_q == 4'd1) begin
        if (marks[MARK_LOOP_END])   end_seen_d   = 1'b1;
        if (marks[MARK_LOOP_START]) start_seen_d = 1'b1;
        if (marks[MARK_STOP])       stopped_d    = 1'b1;
      end
      // a stop byte freezes the frame position
      if (!((pos_q == 4'd1) && marks[MARK_STOP])) begin
        if (pos_q == 4'(FRAME_BYTES - 1)) begin
          pos_d = '0;
          if (32'(cur_inc) >= 32'(nch)) begin
            cur_d   = '0;
            block_d = block_q + 1'b1;
          end else begin
            cur_d = CurW'(cur_inc);
          end
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q   <= 4'd1;
      rep_start_q  <= 1'b1;
      rep_end_q    <= 1'b1;
      pos_q        <= '0;
      cur_q        <= '0;
      shift_q      <= '0;
      filter_q     <= '0;
      block_q      <= '0;
      start_seen_q <= 1'b0;
      end_seen_q   <= 1'b0;
      stopped_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_CHANNELS:     channels_q  <= cfg_data_i;
          REG_REPORT_START: rep_start_q <= cfg_data_i[0];
          REG_REPORT_END:   rep_end_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      pos_q        <= pos_d;
      cur_q        <= cur_d;
      shift_q      <= shift_d;
      filter_q     <= filter_d;
      block_q      <= block_d;
      start_seen_q <= start_seen_d;
      end_seen_q   <= end_seen_d;
      stopped_q    <= stopped_d;
    end
  end

endmodule

>>> design/vagdec_back.sv
// Sample decoder: queued ops to results with channel history, one per cycle unless stalled.
module vagdec_back #(
  parameter int unsigned MAX_CHANNELS = vagdec_pkg::MAX_CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  vagdec_pkg::op_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [15:0]      out_sample_o,
  output logic [7:0]       out_slot_o,
  output logic [25:0]      out_block_o,
  output logic [30:0]      out_loop_o,
  output logic             out_last_o
);
  import vagdec_pkg::*;

  localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [31:0] hist_rec_q [MAX_CHANNELS];
  logic signed [31:0] hist_old_q [MAX_CHANNELS];
  logic [2:0]         done_q;
  logic               out_valid_q;
  kind_e              out_kind_q;
  logic [15:0]        out_sample_q;
  logic [7:0]         out_slot_q;
  logic [25:0]        out_block_q;
  logic [30:0]        out_loop_q;
  logic               out_last_q;

  logic               load;
  logic [ChW-1:0]     chan;
  logic [3:0]         nib;
  logic signed [15:0] x16;
  logic signed [31:0] h1, h2;
  logic signed [39:0] p1, p2;
  logic signed [41:0] acc, acc_r;
  logic signed [35:0] h36;
  logic signed [31:0] hn;
  logic signed [32:0] hr;
  logic signed [24:0] s25;
  logic [15:0]        sample;
  logic [2:0]         rem, pick, rest;
  kind_e              flag_kind;
  logic [30:0]        flag_loop;
  logic               flag_last;

  assign load = !empty_i && (!out_valid_q || out_ready_i);
  assign chan = head_i.chan[ChW-1:0];
  assign nib  = done_q[0] ? head_i.data[7:4] : head_i.data[3:0];

  // nibble to the top of 16 bits, then scale down
  assign x16 = $signed({nib, 12'b0}) >>> head_i.shift;
  assign h1  = hist_rec_q[chan];
  assign h2  = hist_old_q[chan];
  assign p1  = 40'(h1) * 40'(coef_recent(head_i.filter));
  assign p2  = 40'(h2) * 40'(coef_older(head_i.filter));
  assign acc = (42'(x16) <<< 14) + 42'(p1) + 42'(p2);

  // round half away from zero to Q8, saturate to 32 bits
  assign acc_r = acc[41] ? acc + 42'sd31 : acc + 42'sd32;
  assign h36   = 36'(acc_r >>> 6);
  always_comb begin
    if (h36[35:31] == 5'b00000 || h36[35:31] == 5'b11111) begin
      hn = h36[31:0];
    end else begin
      hn = h36[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // round history to an integer, saturate to 16 bits
  assign hr  = hn[31] ? 33'(hn) + 33'sd127 : 33'(hn) + 33'sd128;
  assign s25 = 25'(hr >>> 8);
  always_comb begin
    if (s25[24:15] == 10'h000 || s25[24:15] == 10'h3FF) begin
      sample = s25[15:0];
    end else begin
      sample = s25[24] ? 16'h8000 : 16'h7FFF;
    end
  end

  always_comb begin
    rem = head_i.marks & ~done_q;
    if (rem[MARK_LOOP_END]) begin
      pick      = 3'b001;
      flag_kind = KIND_LOOP_END;
      flag_loop = head_i.base + 31'(SAMPLES_PER_FRAME - 1);
    end else if (rem[MARK_LOOP_START]) begin
      pick      = 3'b010;
      flag_kind = KIND_LOOP_START;
      flag_loop = head_i.base;
    end else begin
      pick      = 3'b100;
      flag_kind = KIND_END;
      flag_loop = '0;
    end
    rest      = rem & ~pick;
    flag_last = (rest == 3'b000);
  end

  assign pop_o = load && (head_i.is_data ? done_q[0] : flag_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_rec_q[i] <= '0;
        hist_old_q[i] <= '0;
      end
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (head_i.is_data) begin
          hist_old_q[chan] <= h1;
          hist_rec_q[chan] <= hn;
          done_q           <= done_q[0] ? 3'b000 : 3'b001;
        end else begin
          done_q <= flag_last ? 3'b000 : (done_q | pick);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_block_q <= head_i.block;
      if (head_i.is_data) begin
        out_kind_q   <= KIND_SAMPLE;
        out_sample_q <= sample;
        out_slot_q   <= done_q[0] ? head_i.slot1 : head_i.slot0;
        out_loop_q   <= '0;
        out_last_q   <= done_q[0];
      end else begin
        out_kind_q   <= flag_kind;
        out_sample_q <= '0;
        out_slot_q   <= '0;
        out_loop_q   <= flag_loop;
        out_last_q   <= flag_last;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_sample_o = out_sample_q;
  assign out_slot_o   = out_slot_q;
  assign out_block_o  = out_block_q;
  assign out_loop_o   = out_loop_q;
  assign out_last_o   = out_last_q;

endmodule
